// File: rtl/phce_pkg.sv
// ----------------------------------------------------------------------------
// phce_pkg
// Shared constants, codes and types of the piecewise Hermite curve evaluator.
// ----------------------------------------------------------------------------
package phce_pkg;

  localparam int SOURCES_DEF = 8;
  localparam int POINTS_DEF  = 16;

  localparam int COORD_W = 16;   // Q3.12
  localparam int T_W     = 17;   // Q1.16
  localparam int CNT_W   = 5;    // point count, slot + 1
  localparam int H_W     = 34;   // basis value, signed Q1.32

  localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [1:0] ST_EVAL_OK = 2'd0;
  localparam logic [1:0] ST_WRITE   = 2'd1;
  localparam logic [1:0] ST_SHORT   = 2'd2;

  typedef struct packed {
    logic signed [H_W-1:0] h1;
    logic signed [H_W-1:0] h2;
    logic signed [H_W-1:0] h3;
    logic signed [H_W-1:0] h4;
  } basis_t;

endpackage

// File: rtl/phce_basis.sv
// ----------------------------------------------------------------------------
// phce_basis
// Three-stage pipeline from local parameter p (Q1.16) to the four cubic
// Hermite basis values, each rounded to signed Q1.32.
// ----------------------------------------------------------------------------
module phce_basis
  import phce_pkg::*;
(
  input  logic           clk,
  input  logic [T_W-1:0] p,
  output basis_t         basis
);

  localparam logic signed [53:0] ONE48  = 54'sh1_0000_0000_0000;
  localparam logic signed [53:0] HALF16 = 54'sh8000;

  logic [T_W-1:0]   p_d1;
  logic [T_W-1:0]   p_d2;
  logic [2*T_W-1:0] p2;
  logic [2*T_W-1:0] p2_d2;
  logic [3*T_W-1:0] p3;

  logic signed [53:0] p3s;
  logic signed [53:0] p2s;
  logic signed [53:0] p1s;
  logic signed [53:0] q1;
  logic signed [53:0] q2;
  logic signed [53:0] q3;
  logic signed [53:0] q4;
  logic signed [53:0] r1;
  logic signed [53:0] r2;
  logic signed [53:0] r3;
  logic signed [53:0] r4;

  always_ff @(posedge clk) begin
    p_d1  <= p;
    p2    <= (2*T_W)'(p) * (2*T_W)'(p);
    p_d2  <= p_d1;
    p2_d2 <= p2;
    p3    <= (3*T_W)'(p2) * (3*T_W)'(p_d1);
  end

  // p3 in Q1.48, p2 lifted to Q1.48, p lifted to Q1.48
  assign p3s = $signed(54'(p3));
  assign p2s = $signed(54'({p2_d2, 16'b0}));
  assign p1s = $signed(54'({p_d2, 32'b0}));

  assign q1 = (p3s <<< 1) - (p2s + (p2s <<< 1)) + ONE48;
  assign q2 = (p2s + (p2s <<< 1)) - (p3s <<< 1);
  assign q3 = p3s - (p2s <<< 1) + p1s;
  assign q4 = p3s - p2s;

  assign r1 = q1 + HALF16;
  assign r2 = q2 + HALF16;
  assign r3 = q3 + HALF16;
  assign r4 = q4 + HALF16;

  always_ff @(posedge clk) begin
    basis.h1 <= r1[16 +: H_W];
    basis.h2 <= r2[16 +: H_W];
    basis.h3 <= r3[16 +: H_W];
    basis.h4 <= r4[16 +: H_W];
  end

endmodule

// File: rtl/phce_blend.sv
// ----------------------------------------------------------------------------
// phce_blend
// One coordinate: tangents, four basis products, rounded sum and saturation
// to Q3.12. Products load on load_en; the saturated sum is registered in the next cycle.
// ----------------------------------------------------------------------------
module phce_blend
  import phce_pkg::*;
(
  input  logic                      clk,
  input  logic                      load_en,
  input  basis_t                    basis,
  input  logic signed [COORD_W-1:0] pt_a,
  input  logic signed [COORD_W-1:0] pt_b,
  input  logic signed [COORD_W-1:0] pt_c,
  input  logic                      use_tan1,
  output logic signed [COORD_W-1:0] pos
);

  localparam int M_W = H_W + COORD_W + 1;
  localparam int S_W = 54;
  localparam int R_W = S_W - 32;
  localparam logic signed [S_W-1:0] HALF32 = 54'sh8000_0000;
  localparam logic signed [R_W-1:0] POS_MAX = 22'sd32767;
  localparam logic signed [R_W-1:0] POS_MIN = -22'sd32768;

  logic signed [COORD_W:0]  tan0;
  logic signed [COORD_W:0]  tan1;
  logic signed [M_W-1:0]    m1;
  logic signed [M_W-1:0]    m2;
  logic signed [M_W-1:0]    m3;
  logic signed [M_W-1:0]    m4;
  logic signed [S_W-1:0]    sum;
  logic signed [R_W-1:0]    rnd;

  assign tan0 = (COORD_W+1)'(pt_b) - (COORD_W+1)'(pt_a);
  assign tan1 = use_tan1 ? (COORD_W+1)'(pt_c) - (COORD_W+1)'(pt_a) : '0;

  always_ff @(posedge clk) begin
    if (load_en) begin
      m1 <= M_W'(basis.h1) * M_W'(pt_a);
      m2 <= M_W'(basis.h2) * M_W'(pt_b);
      m3 <= M_W'(basis.h3) * M_W'(tan0);
      m4 <= M_W'(basis.h4) * M_W'(tan1);
    end
  end

  // Q.44 sum, round half up to Q.12
  assign sum = S_W'(m1) + S_W'(m2) + S_W'(m3) + S_W'(m4) + HALF32;
  assign rnd = sum[S_W-1:32];

  always_ff @(posedge clk) begin
    if (rnd > POS_MAX) begin
      pos <= POS_MAX[COORD_W-1:0];
    end else if (rnd < POS_MIN) begin
      pos <= POS_MIN[COORD_W-1:0];
    end else begin
      pos <= rnd[COORD_W-1:0];
    end
  end

endmodule

// File: rtl/piecewise_hermite_curve_evaluator.sv
// ----------------------------------------------------------------------------
// piecewise_hermite_curve_evaluator
// A write goes to S_DONE; an evaluate passes S_CNT and S_SEG through S_SUM, a
// short or out-of-range curve only S_CNT. One word in flight at a time: a new
// word is taken only after S_DONE has registered the last result, which
// out_stall can delay; the three reads of the single-read-port point memory and
// the basis pipeline set this. Reset clears the per-curve count valid bits; the
// point memory is not cleared and needs no sweep, so the block is ready at once.
// ----------------------------------------------------------------------------
module piecewise_hermite_curve_evaluator
  import phce_pkg::*;
#(
  parameter int SOURCES          = SOURCES_DEF,
  parameter int POINTS_PER_CURVE = POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      op,
  input  logic [2:0]                src_index,
  input  logic [2:0]                dst_index,
  input  logic [3:0]                point_slot,
  input  logic                      is_final_point,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic [T_W-1:0]            param_t,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] pos_x,
  output logic signed [COORD_W-1:0] pos_y,
  output logic [1:0]                status
);

  localparam int CURVES = SOURCES * SOURCES;
  localparam int DEPTH  = CURVES * POINTS_PER_CURVE;
  localparam int CW     = $clog2(CURVES);
  localparam int AW     = $clog2(DEPTH);
  localparam int PR_W   = T_W + CNT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CNT  = 4'd1;
  localparam logic [3:0] S_SEG  = 4'd2;
  localparam logic [3:0] S_RD1  = 4'd3;
  localparam logic [3:0] S_RD2  = 4'd4;
  localparam logic [3:0] S_RD3  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  logic [2*COORD_W-1:0] pt_mem [DEPTH];
  logic [CNT_W-1:0]     cnt_mem [CURVES];
  logic [CURVES-1:0]    cnt_vld;

  logic                 accept;
  logic                 curve_ok_in;
  logic [CW-1:0]        curve_in;
  logic [AW-1:0]        pt_waddr;
  logic                 pt_we;
  logic                 cnt_we;
  logic [AW-1:0]        pt_raddr;
  logic [2*COORD_W-1:0] pt_rdata;
  logic [CNT_W-1:0]     cnt_rdata;
  logic                 cnt_rvld;

  logic [T_W-1:0]   t_q;
  logic [CW-1:0]    curve_q;
  logic             curve_ok_q;
  logic [CNT_W-1:0] n_q;
  logic [PR_W-1:0]  prod_q;
  logic [AW-1:0]    base_q;
  logic [T_W-1:0]   p_q;
  logic             use_t1_q;
  logic [1:0]       status_q;
  logic signed [COORD_W-1:0] ax_q;
  logic signed [COORD_W-1:0] ay_q;
  logic signed [COORD_W-1:0] bx_q;
  logic signed [COORD_W-1:0] by_q;

  logic [CNT_W-1:0] cnt_eff;
  logic             short_curve;
  logic [CNT_W:0]   seg_raw;
  logic [CNT_W-1:0] nm2;
  logic [CNT_W-1:0] seg_calc;
  logic [AW-1:0]    base_calc;
  logic [T_W-1:0]   p_calc;
  logic             use_t1_calc;

  basis_t                    basis;
  logic signed [COORD_W-1:0] blend_x;
  logic signed [COORD_W-1:0] blend_y;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign curve_ok_in = (32'(src_index) < SOURCES) && (32'(dst_index) < SOURCES);
  assign curve_in    = CW'(32'(src_index) * SOURCES + 32'(dst_index));
  assign pt_waddr    = AW'(32'(curve_in) * POINTS_PER_CURVE + 32'(point_slot));
  assign pt_we       = accept && (op == OP_WRITE) && curve_ok_in
                    && (32'(point_slot) < POINTS_PER_CURVE);
  assign cnt_we      = pt_we && is_final_point;

  // count store: valid bit per curve stands in for the all-zero reset
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[curve_in] <= CNT_W'(point_slot) + CNT_W'(1);
    end
    cnt_rdata <= cnt_mem[curve_in];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld  <= '0;
      cnt_rvld <= 1'b0;
    end else begin
      if (cnt_we) begin
        cnt_vld[curve_in] <= 1'b1;
      end
      cnt_rvld <= cnt_vld[curve_in];
    end
  end

  // point store: x in the low half, y in the high half
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= {coord_y, coord_x};
    end
    pt_rdata <= pt_mem[pt_raddr];
  end

  // P[s] lands in S_RD1, P[s+1] in S_RD2, P[s+2] from S_RD3 through S_MUL
  always_comb begin
    case (state)
      S_SEG:   pt_raddr = base_calc;
      S_RD1:   pt_raddr = base_q + AW'(1);
      default: pt_raddr = base_q + AW'(2);
    endcase
  end

  // segment select and local parameter
  assign cnt_eff     = cnt_rvld ? cnt_rdata : '0;
  assign short_curve = !curve_ok_q || (cnt_eff < CNT_W'(2))
                    || (32'(cnt_eff) > POINTS_PER_CURVE);
  assign seg_raw     = prod_q[PR_W-1:16];
  assign nm2         = n_q - CNT_W'(2);
  assign seg_calc    = (seg_raw > {1'b0, nm2}) ? nm2 : seg_raw[CNT_W-1:0];
  assign base_calc   = AW'(32'(curve_q) * POINTS_PER_CURVE + 32'(seg_calc));
  assign p_calc      = T_W'(prod_q - PR_W'({seg_calc, 16'b0}));
  assign use_t1_calc = ({1'b0, seg_calc} + (CNT_W+1)'(2)) < {1'b0, n_q};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (op == OP_EVAL) ? S_CNT : S_DONE;
        end
      end
      S_CNT:   state_next = short_curve ? S_DONE : S_SEG;
      S_SEG:   state_next = S_RD1;
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = S_RD3;
      S_RD3:   state_next = S_MUL;
      S_MUL:   state_next = S_SUM;
      S_SUM:   state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      t_q        <= (param_t > ONE_Q16) ? ONE_Q16 : param_t;
      curve_q    <= curve_in;
      curve_ok_q <= curve_ok_in;
      status_q   <= (op == OP_EVAL) ? ST_EVAL_OK : ST_WRITE;
    end
    if (state == S_CNT) begin
      n_q    <= cnt_eff;
      prod_q <= PR_W'(t_q) * PR_W'(cnt_eff - CNT_W'(1));
      if (short_curve) begin
        status_q <= ST_SHORT;
      end
    end
    if (state == S_SEG) begin
      base_q   <= base_calc;
      p_q      <= p_calc;
      use_t1_q <= use_t1_calc;
    end
    if (state == S_RD1) begin
      ax_q <= pt_rdata[COORD_W-1:0];
      ay_q <= pt_rdata[2*COORD_W-1:COORD_W];
    end
    if (state == S_RD2) begin
      bx_q <= pt_rdata[COORD_W-1:0];
      by_q <= pt_rdata[2*COORD_W-1:COORD_W];
    end
  end

  // p_q settles at the end of S_SEG, so the basis is ready by S_MUL
  phce_basis u_basis (
    .clk   (clk),
    .p     (p_q),
    .basis (basis)
  );

  phce_blend u_blend_x (
    .clk      (clk),
    .load_en  (state == S_MUL),
    .basis    (basis),
    .pt_a     (ax_q),
    .pt_b     (bx_q),
    .pt_c     (pt_rdata[COORD_W-1:0]),
    .use_tan1 (use_t1_q),
    .pos      (blend_x)
  );

  phce_blend u_blend_y (
    .clk      (clk),
    .load_en  (state == S_MUL),
    .basis    (basis),
    .pt_a     (ay_q),
    .pt_b     (by_q),
    .pt_c     (pt_rdata[2*COORD_W-1:COORD_W]),
    .use_tan1 (use_t1_q),
    .pos      (blend_y)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      status <= status_q;
      pos_x  <= (status_q == ST_EVAL_OK) ? blend_x : '0;
      pos_y  <= (status_q == ST_EVAL_OK) ? blend_y : '0;
    end
  end

  a_nonzero_on_non_eval: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_EVAL_OK) |-> (pos_x == '0) && (pos_y == '0))
    else $error("nonzero position on write or error word");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("sequencer stayed idle after accept");

  a_eval_sequence: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEG) |-> ##5 (state == S_SUM))
    else $error("evaluate read sequence broken");

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    pt_we |-> (state == S_IDLE) && (op == OP_WRITE))
    else $error("point write outside idle");

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the piecewise Hermite curve evaluator against a predictor of its own.
// A short table of directed words runs first. Random traffic follows, mostly
// curve loads followed by evaluates, with lone evaluates, stray writes and
// partial loads mixed in. Both handshake sides idle at random, and there is
// one long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
  import phce_pkg::*;

  localparam int NCURVE    = SOURCES_DEF * SOURCES_DEF;
  localparam int NSTORE    = NCURVE * POINTS_DEF;
  localparam int RAND_WORDS = 500;
  localparam int DIR_ROWS  = 22;

  typedef struct packed {
    logic                      op;
    logic [2:0]                src;
    logic [2:0]                dst;
    logic [3:0]                slot;
    logic                      fin;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [T_W-1:0]            t;
    logic                      typed;   // expected result given in the row
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic [1:0]                est;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [1:0]                st;
  } resp_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      op = OP_WRITE;
  logic [2:0]                src_index = '0;
  logic [2:0]                dst_index = '0;
  logic [3:0]                point_slot = '0;
  logic                      is_final_point = 1'b0;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic [T_W-1:0]            param_t = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic [1:0]                status;

  piecewise_hermite_curve_evaluator u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .src_index      (src_index),
    .dst_index      (dst_index),
    .point_slot     (point_slot),
    .is_final_point (is_final_point),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .param_t        (param_t),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .status         (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [COORD_W-1:0] pt_x [NSTORE];
  logic signed [COORD_W-1:0] pt_y [NSTORE];
  bit                        pt_known [NSTORE];
  int                        pt_count [NCURVE];

  resp_t due_results [$];
  req_t  pending_words [$];
  int    errors = 0;
  int    n_accepted = 0;
  int    rand_planned = 0;

  // op src dst slot fin x y t | typed ex ey status
  req_t dir_rows [DIR_ROWS] = '{
    '{OP_EVAL,  0, 0,  0, 0,      0,      0,      0, 1,      0,      0, ST_SHORT},
    '{OP_EVAL,  7, 7,  0, 0,      0,      0,  65536, 1,      0,      0, ST_SHORT},
    '{OP_WRITE, 0, 0,  0, 0,  32767, -32768,      0, 1,      0,      0, ST_WRITE},
    '{OP_EVAL,  0, 0,  0, 0,      0,      0,  32768, 1,      0,      0, ST_SHORT},
    '{OP_WRITE, 0, 0,  1, 1, -32768,  32767,      0, 1,      0,      0, ST_WRITE},
    '{OP_EVAL,  0, 0,  0, 0,      0,      0,      0, 1,  32767, -32768, ST_EVAL_OK},
    '{OP_EVAL,  0, 0,  0, 0,      0,      0,  65536, 1, -32768,  32767, ST_EVAL_OK},
    '{OP_EVAL,  0, 0,  0, 0,      0,      0, 131071, 1, -32768,  32767, ST_EVAL_OK},
    '{OP_EVAL,  0, 0,  0, 0,      0,      0,  32768, 0,      0,      0, ST_EVAL_OK},
    '{OP_EVAL,  0, 0,  0, 0,      0,      0,      1, 0,      0,      0, ST_EVAL_OK},
    '{OP_EVAL,  0, 0,  0, 0,      0,      0,  65535, 0,      0,      0, ST_EVAL_OK},
    '{OP_WRITE, 1, 2,  0, 0,  20000, -20000,      0, 1,      0,      0, ST_WRITE},
    '{OP_WRITE, 1, 2,  1, 0,  32767, -32768,      0, 1,      0,      0, ST_WRITE},
    '{OP_WRITE, 1, 2,  2, 1, -32768,  32767,      0, 1,      0,      0, ST_WRITE},
    '{OP_EVAL,  1, 2,  0, 0,      0,      0,  26214, 0,      0,      0, ST_EVAL_OK},
    '{OP_EVAL,  1, 2,  0, 0,      0,      0,  49152, 0,      0,      0, ST_EVAL_OK},
    '{OP_EVAL,  1, 2,  0, 0,      0,      0,  65536, 1, -32768,  32767, ST_EVAL_OK},
    '{OP_WRITE, 7, 7, 15, 1,     -1,      1,      0, 1,      0,      0, ST_WRITE},
    '{OP_WRITE, 7, 7,  0, 1,     -1,     -1,      0, 1,      0,      0, ST_WRITE},
    '{OP_EVAL,  7, 7,  0, 0,      0,      0,  65536, 1,      0,      0, ST_SHORT},
    '{OP_WRITE, 0, 0,  1, 0,      0,      0,      0, 1,      0,      0, ST_WRITE},
    '{OP_EVAL,  0, 0,  0, 0,      0,      0,  49152, 0,      0,      0, ST_EVAL_OK}
  };

  function automatic void queue_word(input req_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic void queue_result(input resp_t r);
    due_results = {due_results, r};
  endfunction

  // Q1.48 basis rounded to Q1.32; >>> on longint floors
  function automatic longint round_q32(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [COORD_W-1:0] blend_coord(
    input longint h1, input longint h2, input longint h3, input longint h4,
    input longint a, input longint b, input longint c, input bit has_c);
    longint tan1;
    longint acc;
    tan1 = has_c ? c - a : longint'(0);
    acc = h1 * a + h2 * b + h3 * (b - a) + h4 * tan1;
    acc = (acc + (longint'(1) << 31)) >>> 32;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return acc[COORD_W-1:0];
  endfunction

  // updates the point lists and returns the word's result
  function automatic resp_t curve_response(input req_t w);
    resp_t  r;
    int     crv;
    int     n;
    int     seg;
    int     base;
    longint t;
    longint prod;
    longint p;
    longint p2;
    longint p3;
    longint h1;
    longint h2;
    longint h3;
    longint h4;
    bit     has_c;
    r = '0;
    crv = int'(w.src) * SOURCES_DEF + int'(w.dst);
    if (w.op == OP_WRITE) begin
      pt_x[crv * POINTS_DEF + int'(w.slot)] = w.x;
      pt_y[crv * POINTS_DEF + int'(w.slot)] = w.y;
      pt_known[crv * POINTS_DEF + int'(w.slot)] = 1'b1;
      if (w.fin) pt_count[crv] = int'(w.slot) + 1;
      r.st = ST_WRITE;
      return r;
    end
    n = pt_count[crv];
    if (n < 2) begin
      r.st = ST_SHORT;
      return r;
    end
    t = longint'(w.t);
    if (t > 65536) t = 65536;
    prod = t * (n - 1);
    seg = int'(prod >> 16);
    if (seg > n - 2) seg = n - 2;
    p = prod - (longint'(seg) << 16);
    p2 = p * p;
    p3 = p2 * p;
    h1 = round_q32(2 * p3 - 3 * p2 * 65536 + (longint'(1) << 48));
    h2 = round_q32(-2 * p3 + 3 * p2 * 65536);
    h3 = round_q32(p3 - 2 * p2 * 65536 + p * (longint'(1) << 32));
    h4 = round_q32(p3 - p2 * 65536);
    base = crv * POINTS_DEF + seg;
    has_c = (seg + 2 < n);
    r.x = blend_coord(h1, h2, h3, h4, longint'(pt_x[base]), longint'(pt_x[base + 1]),
                      has_c ? longint'(pt_x[base + 2]) : longint'(0), has_c);
    r.y = blend_coord(h1, h2, h3, h4, longint'(pt_y[base]), longint'(pt_y[base + 1]),
                      has_c ? longint'(pt_y[base + 2]) : longint'(0), has_c);
    r.st = ST_EVAL_OK;
    return r;
  endfunction

  // an evaluate may only read points that were written
  function automatic bit curve_safe(input int crv);
    int i;
    if (pt_count[crv] < 2) return 1'b1;
    for (i = 0; i < pt_count[crv]; i++)
      if (!pt_known[crv * POINTS_DEF + i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [T_W-1:0] pick_t();
    int r;
    r = $urandom_range(99);
    if (r < 50) return T_W'($urandom_range(65536));
    if (r < 65) begin
      case ($urandom_range(3))
        0: return '0;
        1: return T_W'(1);
        2: return T_W'(65535);
        default: return ONE_Q16;
      endcase
    end
    if (r < 80) return T_W'($urandom_range(131071, 65537));
    return T_W'($urandom);
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: return 16'sh7fff;
        1: return 16'sh8000;
        2: return '0;
        default: return -16'sd1;
      endcase
    end
    return COORD_W'($urandom);
  endfunction

  task automatic plan_write(input int s, input int d, input int slot, input bit fin);
    req_t w;
    w = '0;
    w.op = OP_WRITE;
    w.src = 3'(s);
    w.dst = 3'(d);
    w.slot = 4'(slot);
    w.fin = fin;
    w.x = pick_coord();
    w.y = pick_coord();
    w.t = T_W'($urandom);  // ignored on a write
    queue_word(w);
    rand_planned++;
  endtask

  task automatic plan_eval(input int s, input int d);
    req_t w;
    w = '0;
    w.op = OP_EVAL;
    w.src = 3'(s);
    w.dst = 3'(d);
    w.slot = 4'($urandom);
    w.fin = 1'($urandom);
    w.x = COORD_W'($urandom);
    w.y = COORD_W'($urandom);
    w.t = pick_t();
    queue_word(w);
    rand_planned++;
  endtask

  // plans the next group of random words from the current curve state
  task automatic plan_traffic();
    int  roll;
    int  s;
    int  d;
    int  n;
    int  k;
    int  i;
    bit  ok;
    roll = $urandom_range(99);
    s = $urandom_range(7);
    d = $urandom_range(7);
    if (roll < 55) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(16, 6) : $urandom_range(5, 2);
      for (i = 0; i < n; i++) plan_write(s, d, i, i == n - 1);
      k = $urandom_range(6, 1);
      for (i = 0; i < k; i++) plan_eval(s, d);
    end else if (roll < 75) begin
      ok = curve_safe(s * SOURCES_DEF + d);
      for (i = 0; i < 8 && !ok; i++) begin
        s = $urandom_range(7);
        d = $urandom_range(7);
        ok = curve_safe(s * SOURCES_DEF + d);
      end
      if (ok) plan_eval(s, d);
      else plan_write(s, d, $urandom_range(15), 1'($urandom_range(1)));
    end else if (roll < 90) begin
      plan_write(s, d, $urandom_range(15), $urandom_range(9) < 3);
    end else begin
      // partial load, then closed at one of the written slots
      k = $urandom_range(6, 1);
      for (i = 0; i < k; i++) plan_write(s, d, i, 1'b0);
      plan_write(s, d, $urandom_range(k - 1), 1'b1);
      k = $urandom_range(3, 1);
      for (i = 0; i < k; i++) plan_eval(s, d);
    end
  endtask

  function automatic int idle_pct();
    return (n_accepted >= 150 && n_accepted < 250) ? 0 : 34;
  endfunction

  initial begin : sender
    req_t  cur;
    resp_t got;
    int    i;
    int    waited;
    bit    done;
    cur = '0;
    done = 1'b0;
    for (i = 0; i < NCURVE; i++) pt_count[i] = 0;
    for (i = 0; i < NSTORE; i++) pt_known[i] = 1'b0;
    for (i = 0; i < DIR_ROWS; i++) queue_word(dir_rows[i]);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (!done) begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        got = curve_response(cur);
        if (cur.typed) begin
          got.x = cur.ex;
          got.y = cur.ey;
          got.st = cur.est;
        end
        queue_result(got);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() == 0 && rand_planned < RAND_WORDS) plan_traffic();
        if (pending_words.size() == 0) begin
          in_valid <= 1'b0;
          done = 1'b1;
        end else if ($urandom_range(99) < idle_pct()) begin
          in_valid <= 1'b0;
        end else begin
          cur = pending_words.pop_front();
          in_valid       <= 1'b1;
          op             <= cur.op;
          src_index      <= cur.src;
          dst_index      <= cur.dst;
          point_slot     <= cur.slot;
          is_final_point <= cur.fin;
          coord_x        <= cur.x;
          coord_y        <= cur.y;
          param_t        <= cur.t;
        end
      end
    end
    waited = 0;
    while (due_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (due_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, due_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // output back-pressure, with one long hold-off once traffic is flowing
  initial begin : receiver
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && n_accepted >= 350) begin
        held = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct());
      end
    end
  end

  always @(posedge clk) begin : check_out
    resp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d status=%0d",
                 $time, pos_x, pos_y, status);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (pos_x !== want.x) begin
          $display("%0t: pos_x expected %0d got %0d", $time, want.x, pos_x);
          errors++;
        end
        if (pos_y !== want.y) begin
          $display("%0t: pos_y expected %0d got %0d", $time, want.y, pos_y);
          errors++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d got %0d", $time, want.st, status);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
rtl/phce_pkg.sv
rtl/phce_basis.sv
rtl/phce_blend.sv
rtl/piecewise_hermite_curve_evaluator.sv
dv/testbench.sv
